// ===== src/bfa_pkg.sv =====
// ----------------------------------------------------------------------------
// bfa_pkg
// Shared types and constants for the bitmap frame allocator: request and
// response payloads, request kinds and default sizes.
// ----------------------------------------------------------------------------
package bfa_pkg;

   // default sizing of the occupancy bitmap
   localparam int MAX_FRAMES_DEF    = 256;
   localparam int MAP_WORD_BITS_DEF = 32;

   // field widths
   localparam int KIND_W  = 1;
   localparam int FRAME_W = 8;
   localparam int COUNT_W = 9;
   localparam int CSR_W   = 9;

   // frames in use after reset
   localparam logic [CSR_W-1:0] FRAMES_RESET = 9'd256;

   // request kinds
   localparam logic [KIND_W-1:0] KIND_ALLOC   = 1'b0;
   localparam logic [KIND_W-1:0] KIND_RELEASE = 1'b1;

   typedef struct packed {
      logic [KIND_W-1:0]  kind;
      logic [FRAME_W-1:0] frame;
   } req_type;

   typedef struct packed {
      logic [FRAME_W-1:0] frame_index;
      logic               ok;
      logic [COUNT_W-1:0] free_count;
   } rsp_type;

endpackage

// ===== src/bitmap_frame_allocator_unit.sv =====
// ----------------------------------------------------------------------------
// bitmap_frame_allocator_unit
// First-fit physical frame allocator over an occupancy bitmap held in a
// word-wide synchronous memory.
// ----------------------------------------------------------------------------
// The single memory read port delivers one bitmap word per cycle, and every
// request sweeps all words to find the lowest free frame, apply the release
// and recount the free frames in use. One request is in flight at a time; the
// next request is taken while the previous response still waits in the
// output register. The bitmap reads as all free after reset with no clearing
// pass: a valid bit per memory word marks words that have been written since
// reset. csr_wr_data sets the number of frames in use (saturated to
// MAX_FRAMES) and may change only while idle.
// ----------------------------------------------------------------------------
module bitmap_frame_allocator_unit #(
   parameter int MAX_FRAMES    = bfa_pkg::MAX_FRAMES_DEF,
   parameter int MAP_WORD_BITS = bfa_pkg::MAP_WORD_BITS_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   // request channel
   input  logic                     req_valid,
   output logic                     req_ready,
   input  bfa_pkg::req_type         req_data,
   // response channel
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output bfa_pkg::rsp_type         rsp_data,
   // configuration
   input  logic                     csr_wr_en,
   input  logic [bfa_pkg::CSR_W-1:0] csr_wr_data
);

   localparam int MAP_WORDS = (MAX_FRAMES + MAP_WORD_BITS - 1) / MAP_WORD_BITS;
   localparam int WPTR_W    = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
   localparam int SUM_W     = $clog2(MAX_FRAMES + MAP_WORD_BITS + 1);
   localparam int EXT_W     = (SUM_W > bfa_pkg::CSR_W) ? SUM_W : bfa_pkg::CSR_W;
   localparam int CNT_W     = $clog2(MAX_FRAMES + 1);
   localparam int PICK_W    = $clog2(MAP_WORD_BITS);
   localparam int PC_W      = $clog2(MAP_WORD_BITS + 1);
   localparam logic [WPTR_W-1:0] LAST_WORD = WPTR_W'(MAP_WORDS - 1);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DONE
   } state_type;

   // control and request state
   state_type                state_ff;
   logic [bfa_pkg::CSR_W-1:0] csr_frames_ff;
   logic [bfa_pkg::KIND_W-1:0] kind_ff;
   logic [EXT_W-1:0]         frame_ff;
   logic [EXT_W-1:0]         n_ff;
   logic                     rel_ok_ff;
   logic                     issue_on_ff;
   logic [WPTR_W-1:0]        issue_ptr_ff;
   logic                     proc_vld_ff;
   logic [WPTR_W-1:0]        proc_ptr_ff;
   logic [EXT_W-1:0]         base_ff;
   logic                     found_ff;
   logic [EXT_W-1:0]         idx_ff;
   logic [CNT_W-1:0]         cnt_ff;
   logic [MAP_WORDS-1:0]     row_vld_ff;
   logic                     rsp_valid_ff;
   bfa_pkg::rsp_type         rsp_data_ff;

   // bitmap memory and its read register
   logic [MAP_WORD_BITS-1:0] map_mem [MAP_WORDS];
   logic [MAP_WORD_BITS-1:0] mem_q_ff;
   logic                     q_vld_ff;

   // request-side derived values
   logic [EXT_W-1:0]         cfg_ext;
   logic [EXT_W-1:0]         n_in;
   logic [EXT_W-1:0]         frame_in;

   // word processing
   logic [MAP_WORD_BITS-1:0] word_eff;
   logic [MAP_WORD_BITS-1:0] in_rng;
   logic [MAP_WORD_BITS-1:0] hit;
   logic [MAP_WORD_BITS-1:0] free_vec;
   logic [MAP_WORD_BITS-1:0] new_word;
   logic                     any_free;
   logic                     take_alloc;
   logic [PICK_W-1:0]        pick;
   logic [PC_W-1:0]          pc;
   logic                     wr_en;
   logic                     accept;
   logic                     rsp_free;

   assign accept    = req_valid && req_ready;
   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;
   assign rsp_free  = !rsp_valid_ff || rsp_ready;

   // saturate the frame count and widen the frame number
   assign cfg_ext  = EXT_W'(csr_frames_ff);
   assign n_in     = (cfg_ext > EXT_W'(MAX_FRAMES)) ? EXT_W'(MAX_FRAMES) : cfg_ext;
   assign frame_in = EXT_W'(req_data.frame);

   // decode range, release hit and lowest free bit of the word under process
   always_comb begin
      word_eff = q_vld_ff ? mem_q_ff : '0;
      for (int j = 0; j < MAP_WORD_BITS; j++) begin
         in_rng[j] = (base_ff + EXT_W'(j)) < n_ff;
         hit[j]    = (base_ff + EXT_W'(j)) == frame_ff;
      end
      free_vec = ~word_eff & in_rng;
      any_free = |free_vec;
      pick     = '0;
      for (int j = MAP_WORD_BITS - 1; j >= 0; j--) begin
         if (free_vec[j]) begin
            pick = PICK_W'(j);
         end
      end
      take_alloc = (kind_ff == bfa_pkg::KIND_ALLOC) && !found_ff && any_free;
      new_word   = word_eff;
      if (take_alloc) begin
         new_word[pick] = 1'b1;
      end
      if ((kind_ff == bfa_pkg::KIND_RELEASE) && rel_ok_ff) begin
         new_word = new_word & ~hit;
      end
      pc = '0;
      for (int j = 0; j < MAP_WORD_BITS; j++) begin
         pc = pc + PC_W'(~new_word[j] & in_rng[j]);
      end
   end

   assign wr_en = (state_ff == ST_SCAN) && proc_vld_ff;

   // write back the modified word
   always_ff @(posedge clock) begin
      if (wr_en) begin
         map_mem[proc_ptr_ff] <= new_word;
      end
   end

   // read one word per cycle
   always_ff @(posedge clock) begin
      mem_q_ff <= map_mem[issue_ptr_ff];
      q_vld_ff <= row_vld_ff[issue_ptr_ff];
   end

   // sequence the sweep and hold the response
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         csr_frames_ff <= bfa_pkg::FRAMES_RESET;
         issue_on_ff   <= 1'b0;
         issue_ptr_ff  <= '0;
         proc_vld_ff   <= 1'b0;
         found_ff      <= 1'b0;
         row_vld_ff    <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            csr_frames_ff <= csr_wr_data;
         end
         // drop the response once taken, unless the next one loads now
         if (rsp_valid_ff && rsp_ready && (state_ff != ST_DONE)) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  kind_ff      <= req_data.kind;
                  frame_ff     <= frame_in;
                  n_ff         <= n_in;
                  rel_ok_ff    <= frame_in < n_in;
                  issue_on_ff  <= 1'b1;
                  issue_ptr_ff <= '0;
                  proc_vld_ff  <= 1'b0;
                  base_ff      <= '0;
                  found_ff     <= 1'b0;
                  idx_ff       <= '0;
                  cnt_ff       <= '0;
                  state_ff     <= ST_SCAN;
               end
            end
            ST_SCAN: begin
               // advance the read pointer
               proc_vld_ff <= issue_on_ff;
               proc_ptr_ff <= issue_ptr_ff;
               if (issue_on_ff) begin
                  if (issue_ptr_ff == LAST_WORD) begin
                     issue_on_ff <= 1'b0;
                  end else begin
                     issue_ptr_ff <= issue_ptr_ff + WPTR_W'(1);
                  end
               end
               // fold in the word just written back
               if (proc_vld_ff) begin
                  row_vld_ff[proc_ptr_ff] <= 1'b1;
                  base_ff <= base_ff + EXT_W'(MAP_WORD_BITS);
                  cnt_ff  <= cnt_ff + CNT_W'(pc);
                  if (take_alloc) begin
                     found_ff <= 1'b1;
                     idx_ff   <= base_ff + EXT_W'(pick);
                  end
                  if (!issue_on_ff) begin
                     state_ff <= ST_DONE;
                  end
               end
            end
            ST_DONE: begin
               if (rsp_free) begin
                  rsp_valid_ff         <= 1'b1;
                  rsp_data_ff.free_count <= bfa_pkg::COUNT_W'(cnt_ff);
                  if (kind_ff == bfa_pkg::KIND_RELEASE) begin
                     rsp_data_ff.ok          <= rel_ok_ff;
                     rsp_data_ff.frame_index <= frame_ff[bfa_pkg::FRAME_W-1:0];
                  end else begin
                     rsp_data_ff.ok          <= found_ff;
                     rsp_data_ff.frame_index <= idx_ff[bfa_pkg::FRAME_W-1:0];
                  end
                  issue_ptr_ff <= '0;
                  state_ff     <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   // a request starts its sweep at the first bitmap word
   a_sweep_start: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff == ST_SCAN) && issue_on_ff && (issue_ptr_ff == '0))
      else $error("sweep did not start at word zero");

   // the last word processed ends the sweep
   a_sweep_end: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) && proc_vld_ff && !issue_on_ff |=> (state_ff == ST_DONE))
      else $error("sweep did not finish after the last word");

   // an allocated frame lies within the frames in use
   a_alloc_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DONE) && found_ff |-> (idx_ff < n_ff))
      else $error("allocated frame outside the frames in use");

   // the free count never exceeds the frames in use
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DONE) |-> (EXT_W'(cnt_ff) <= n_ff))
      else $error("free count above frames in use");

   // only allocate requests find a frame
   a_found_kind: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) && found_ff |-> (kind_ff == bfa_pkg::KIND_ALLOC))
      else $error("frame found on a release request");

endmodule

// ===== dv/tb_bitmap_frame_allocator_unit.sv =====
// ----------------------------------------------------------------------------
// tb_bitmap_frame_allocator_unit
// Self-checking bench for the first-fit frame allocator. Requests go in over
// a valid/ready channel. An in-bench bitmap predicts each response when its
// request is accepted. A monitor compares every response, field by field,
// with the oldest prediction. Phases cover directed corner cases,
// map exhaustion, a long response hold-off, a saturated frame count, random
// counts and a zero count. Sender gaps and receiver stalls vary per phase.
// ----------------------------------------------------------------------------
module tb_bitmap_frame_allocator_unit;

   logic                       clock       = 1'b0;
   logic                       reset       = 1'b1;
   logic                       req_valid   = 1'b0;
   logic                       req_ready;
   bfa_pkg::req_type           req_data    = '0;
   logic                       rsp_valid;
   logic                       rsp_ready   = 1'b0;
   bfa_pkg::rsp_type           rsp_data;
   logic                       csr_wr_en   = 1'b0;
   logic [bfa_pkg::CSR_W-1:0]  csr_wr_data = '0;

   // in-bench copy of the occupancy bitmap and the frame count
   logic                       occupied_bits [bfa_pkg::MAX_FRAMES_DEF];
   logic [bfa_pkg::CSR_W-1:0]  frames_limit;
   bfa_pkg::rsp_type           pending_responses [$];
   bfa_pkg::rsp_type           oldest_response;

   // idling controls: 0 none, 1 light, 2 heavy
   int                 send_idle   = 0;
   int                 recv_idle   = 0;
   int                 burst_left  = 0;
   int                 stall_left  = 0;
   int                 hold_left   = 0;

   // run statistics
   int                 mismatches      = 0;
   int                 requests_sent   = 0;
   int                 responses_seen  = 0;
   int                 allocs_granted  = 0;
   int                 allocs_refused  = 0;
   int                 releases_done   = 0;
   int                 releases_refused = 0;

   bitmap_frame_allocator_unit i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always #4 clock = ~clock;

   // ------------------------------------------------------------------------
   // Prediction
   // ------------------------------------------------------------------------

   // clamp the programmed count to the bitmap size
   function automatic int effective_frames();
      return (frames_limit > bfa_pkg::CSR_W'(bfa_pkg::MAX_FRAMES_DEF)) ?
             bfa_pkg::MAX_FRAMES_DEF : int'(frames_limit);
   endfunction

   // apply one accepted request to the bitmap and return its response
   function automatic bfa_pkg::rsp_type apply_frame_request(bfa_pkg::req_type r);
      bfa_pkg::rsp_type want;
      int      n;
      int      free_frames;
      bit      found;
      n           = effective_frames();
      want        = '0;
      found       = 1'b0;
      free_frames = 0;
      if (r.kind == bfa_pkg::KIND_ALLOC) begin
         for (int i = 0; i < n; i++) begin
            if (!found && !occupied_bits[i]) begin
               occupied_bits[i] = 1'b1;
               want.frame_index = bfa_pkg::FRAME_W'(i);
               want.ok          = 1'b1;
               found            = 1'b1;
            end
         end
         if (found) allocs_granted++;
         else allocs_refused++;
      end else begin
         want.frame_index = r.frame;
         if (int'(r.frame) < n) begin
            occupied_bits[r.frame] = 1'b0;
            want.ok                = 1'b1;
            releases_done++;
         end else begin
            releases_refused++;
         end
      end
      for (int i = 0; i < n; i++)
         if (!occupied_bits[i]) free_frames++;
      want.free_count = bfa_pkg::COUNT_W'(free_frames);
      return want;
   endfunction

   // build a request: mostly allocations and releases of held frames,
   // with some releases of arbitrary frames as noise
   function automatic bfa_pkg::req_type pick_request(int alloc_pct);
      bfa_pkg::req_type r;
      int      roll;
      int      n;
      int      start;
      int      j;
      bit      found;
      roll    = $urandom_range(0, 99);
      n       = effective_frames();
      r.frame = bfa_pkg::FRAME_W'($urandom);
      found   = 1'b0;
      if (roll < alloc_pct) begin
         r.kind = bfa_pkg::KIND_ALLOC;
      end else begin
         r.kind = bfa_pkg::KIND_RELEASE;
         if (roll < alloc_pct + 12 || n == 0) return r;
         start = $urandom_range(0, n - 1);
         for (int k = 0; k < n; k++) begin
            j = (start + k) % n;
            if (!found && occupied_bits[j]) begin
               r.frame = bfa_pkg::FRAME_W'(j);
               found   = 1'b1;
            end
         end
      end
      return r;
   endfunction

   // ------------------------------------------------------------------------
   // Response side: stall pattern, long hold-off and checking
   // ------------------------------------------------------------------------

   // drop ready for a hold-off, a stall run, or at random
   always @(posedge clock) begin
      if (hold_left > 0) begin
         rsp_ready <= 1'b0;
         hold_left <= hold_left - 1;
      end else if (stall_left > 0) begin
         rsp_ready  <= 1'b0;
         stall_left <= stall_left - 1;
      end else if (recv_idle > 0 && $urandom_range(0, 99) < 20 * recv_idle) begin
         rsp_ready  <= 1'b0;
         stall_left <= $urandom_range(0, (recv_idle == 1) ? 2 : 14);
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   task automatic report_mismatch(input string what, input bfa_pkg::rsp_type want,
                                  input bfa_pkg::rsp_type got);
      mismatches++;
      if (mismatches <= 10) begin
         $display("mismatch (%s) at %0t: expected idx=%0d ok=%0d free=%0d",
                  what, $time, want.frame_index, want.ok, want.free_count);
         $display("   got idx=%0d ok=%0d free=%0d",
                  got.frame_index, got.ok, got.free_count);
      end
   endtask

   // compare each accepted response with the oldest prediction
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         responses_seen++;
         if (pending_responses.size() == 0) begin
            report_mismatch("unexpected response", '0, rsp_data);
         end else begin
            oldest_response = pending_responses.pop_front();
            if (rsp_data.frame_index !== oldest_response.frame_index ||
                rsp_data.ok !== oldest_response.ok ||
                rsp_data.free_count !== oldest_response.free_count)
               report_mismatch("field", oldest_response, rsp_data);
         end
      end
   end

   // ------------------------------------------------------------------------
   // Request side
   // ------------------------------------------------------------------------

   // offer one request in bursts with random gaps, predict it on acceptance
   task automatic send_request(input bfa_pkg::req_type r);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 20);
         gap = (send_idle == 0) ? 0 : $urandom_range(0, (send_idle == 1) ? 3 : 12);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_valid <= 1'b1;
      req_data  <= r;
      do @(posedge clock); while (!(req_valid && req_ready));
      requests_sent++;
      pending_responses.push_back(apply_frame_request(r));
   endtask

   task automatic send_kind(input logic [bfa_pkg::KIND_W-1:0] kind, input int frame);
      bfa_pkg::req_type r;
      r.kind  = kind;
      r.frame = bfa_pkg::FRAME_W'(frame);
      send_request(r);
   endtask

   task automatic run_random(input int count, input int alloc_pct);
      for (int i = 0; i < count; i++)
         send_request(pick_request(alloc_pct));
   endtask

   // stop offering and wait until every predicted response has arrived
   task automatic drain_responses();
      req_valid  <= 1'b0;
      burst_left = 0;
      do @(posedge clock); while (pending_responses.size() != 0);
   endtask

   // program the frame count while the block is idle
   task automatic write_frames(input logic [bfa_pkg::CSR_W-1:0] value);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en    <= 1'b0;
      frames_limit = value;
   endtask

   task automatic set_idling(input int s, input int r);
      send_idle = s;
      recv_idle = r;
   endtask

   // ------------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------------

   // corner cases: first fit, reuse, full map, out of range, zero and
   // saturated counts, shrunk map keeping its bits
   task automatic test_directed();
      set_idling(0, 0);
      send_kind(bfa_pkg::KIND_ALLOC, 0);
      send_kind(bfa_pkg::KIND_ALLOC, 255);
      send_kind(bfa_pkg::KIND_ALLOC, 0);
      send_kind(bfa_pkg::KIND_RELEASE, 1);
      send_kind(bfa_pkg::KIND_ALLOC, 0);
      send_kind(bfa_pkg::KIND_RELEASE, 255);
      send_kind(bfa_pkg::KIND_RELEASE, 2);
      send_kind(bfa_pkg::KIND_ALLOC, 0);
      drain_responses();
      write_frames(bfa_pkg::CSR_W'(4));
      send_kind(bfa_pkg::KIND_ALLOC, 0);
      send_kind(bfa_pkg::KIND_ALLOC, 0);
      send_kind(bfa_pkg::KIND_RELEASE, 4);
      send_kind(bfa_pkg::KIND_RELEASE, 3);
      send_kind(bfa_pkg::KIND_ALLOC, 0);
      drain_responses();
      write_frames('0);
      send_kind(bfa_pkg::KIND_ALLOC, 0);
      send_kind(bfa_pkg::KIND_RELEASE, 0);
      drain_responses();
      write_frames('1);
      send_kind(bfa_pkg::KIND_ALLOC, 0);
      send_kind(bfa_pkg::KIND_RELEASE, 255);
      send_kind(bfa_pkg::KIND_ALLOC, 0);
      drain_responses();
      write_frames(bfa_pkg::CSR_W'(1));
      send_kind(bfa_pkg::KIND_RELEASE, 0);
      send_kind(bfa_pkg::KIND_ALLOC, 0);
      send_kind(bfa_pkg::KIND_ALLOC, 0);
      send_kind(bfa_pkg::KIND_RELEASE, 1);
      drain_responses();
   endtask

   // allocation-heavy traffic on the full map
   task automatic test_fill_and_exhaust();
      write_frames(bfa_pkg::FRAMES_RESET);
      set_idling(2, 2);
      run_random(400, 75);
      drain_responses();
   endtask

   // back-to-back traffic with no idling on an odd-sized map
   task automatic test_balanced_no_idle();
      write_frames(bfa_pkg::CSR_W'(37));
      set_idling(0, 0);
      run_random(300, 50);
      drain_responses();
   endtask

   // hold responses off long enough that the block stalls its input
   task automatic test_backpressure();
      write_frames(bfa_pkg::CSR_W'(8));
      set_idling(0, 1);
      hold_left = 300;
      run_random(150, 55);
      drain_responses();
   endtask

   // counts above the bitmap size, with a full drain midway
   task automatic test_saturated_count();
      write_frames(bfa_pkg::CSR_W'(511));
      set_idling(1, 1);
      run_random(120, 60);
      drain_responses();
      run_random(120, 45);
      drain_responses();
      write_frames(bfa_pkg::CSR_W'(300));
      run_random(100, 55);
      drain_responses();
   endtask

   // random counts, small ones often, shrinking and growing the map
   task automatic test_random_sizes();
      int sel;
      for (int round = 0; round < 5; round++) begin
         sel = $urandom_range(0, 2);
         case (sel)
            0: write_frames(bfa_pkg::CSR_W'($urandom_range(1, 16)));
            1: write_frames(bfa_pkg::CSR_W'($urandom_range(17, 256)));
            default: write_frames(bfa_pkg::CSR_W'($urandom_range(257, 511)));
         endcase
         set_idling($urandom_range(0, 2), $urandom_range(0, 2));
         run_random(140, $urandom_range(40, 70));
         drain_responses();
      end
   endtask

   // no frames in use: every request fails
   task automatic test_zero_frames();
      write_frames('0);
      set_idling(1, 2);
      run_random(40, 50);
      drain_responses();
      write_frames(bfa_pkg::FRAMES_RESET);
   endtask

   // ------------------------------------------------------------------------
   // Sequence
   // ------------------------------------------------------------------------
   initial begin
      foreach (occupied_bits[i]) occupied_bits[i] = 1'b0;
      frames_limit = bfa_pkg::FRAMES_RESET;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed();
      test_fill_and_exhaust();
      test_balanced_no_idle();
      test_backpressure();
      test_saturated_count();
      test_random_sizes();
      test_zero_frames();

      // let any stray response show up before closing
      drain_responses();
      repeat (20) @(posedge clock);
      if (pending_responses.size() != 0) begin
         mismatches++;
         $display("%0d predicted responses never arrived", pending_responses.size());
      end

      $display("covered %0d requests and %0d responses: %0d grants, %0d refusals on a full map",
               requests_sent, responses_seen, allocs_granted, allocs_refused);
      $display("releases %0d accepted, %0d out of range; %0d mismatches",
               releases_done, releases_refused, mismatches);
      if (mismatches == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

   // watchdog on a hung handshake
   initial begin
      #(8 * 500000);
      $display("timeout at %0t", $time);
      $display("status: fail");
      $finish;
   end

endmodule
